>>> rtl/core/gdl90_pkg.sv
// ----------------------------------------------------------------------------
// gdl90_pkg
// Shared constants, command type and CRC-16 helpers for the frame encoder.
// ----------------------------------------------------------------------------
package gdl90_pkg;

    localparam logic [7:0]  FLAG_BYTE = 8'h7E;
    localparam logic [7:0]  ESC_BYTE  = 8'h7D;
    localparam logic [7:0]  ESC_XOR   = 8'h20;
    localparam logic [15:0] CRC_SEED  = 16'h0000;
    localparam logic [15:0] CRC_POLY  = 16'h1021;

    // One accepted, framed message byte as handed from front to back.
    typedef struct packed {
        logic        first;
        logic        last;
        logic [7:0]  data;
        logic [15:0] crc;    // running CRC after this byte
    } cmd_t;

    // T[idx]: idx << 8 reduced bitwise by the polynomial.
    function automatic logic [15:0] crc_table_entry(input logic [7:0] idx);
        logic [15:0] v;
        v = {idx, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            if (v[15])
                v = {v[14:0], 1'b0} ^ CRC_POLY;
            else
                v = {v[14:0], 1'b0};
        end
        return v;
    endfunction

    function automatic logic [15:0] crc_update(input logic [15:0] crc,
                                               input logic [7:0]  b);
        return crc_table_entry(crc[15:8]) ^ {crc[7:0], 8'h00} ^ {8'h00, b};
    endfunction

    function automatic logic needs_escape(input logic [7:0] b);
        return (b == ESC_BYTE) || (b == FLAG_BYTE);
    endfunction

endpackage

>>> rtl/core/gdl90_stream_if.sv
// ----------------------------------------------------------------------------
// gdl90 stream interfaces
// Valid/ready channels for message bytes in and framed bytes out.
// ----------------------------------------------------------------------------
interface gdl90_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;

    modport source (output valid, data_byte, first_byte, last_byte, input ready);
    modport sink   (input valid, data_byte, first_byte, last_byte, output ready);
endinterface

interface gdl90_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       frame_end;
    logic       run_last;

    modport source (output valid, out_byte, frame_end, run_last, input ready);
    modport sink   (input valid, out_byte, frame_end, run_last, output ready);
endinterface

>>> rtl/core/gdl90_frame_encoder.sv
// ----------------------------------------------------------------------------
// gdl90_frame_encoder
// Framing, byte stuffing and CRC-16 for a message byte stream.
// ----------------------------------------------------------------------------
//  channel   dir   handshake      payload
//  in_ch     in    valid/ready    data_byte[7:0], first_byte, last_byte
//  out_ch    out   valid/ready    out_byte[7:0], frame_end, run_last
//
//  One back-end byte per unstalled cycle; an input byte costs 1 to 2 output
//  bytes, plus 1 (opening flag) on an id and 3 to 5 on a last byte.
//  Input is taken every cycle while the command queue (QUEUE_DEPTH) has room.
//  Reset clears CRC, frame state, queue and output valid; no clearing pass.
//  Output stalls hold the registered byte and back-pressure via the queue.
// ----------------------------------------------------------------------------
module gdl90_frame_encoder
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    gdl90_in_if.sink    in_ch,
    gdl90_out_if.source out_ch
);
    import gdl90_pkg::*;

    cmd_t push_cmd;
    cmd_t head_cmd;
    logic push;
    logic full;
    logic pop;
    logic empty;

    gdl90_front u_front
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .q_full (full),
        .q_push (push),
        .q_cmd  (push_cmd)
    );

    gdl90_cmd_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (full),
        .pop      (pop),
        .empty    (empty),
        .head_cmd (head_cmd)
    );

    gdl90_back u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (empty),
        .q_head  (head_cmd),
        .q_pop   (pop),
        .out_ch  (out_ch)
    );

endmodule

>>> rtl/core/gdl90_front.sv
// ----------------------------------------------------------------------------
// gdl90_front
// Accepts message bytes, tracks frame state, runs the CRC, queues commands.
// ----------------------------------------------------------------------------
module gdl90_front
(
    input  logic             clk,
    input  logic             rst_n,
    gdl90_in_if.sink         in_ch,
    input  logic             q_full,
    output logic             q_push,
    output gdl90_pkg::cmd_t  q_cmd
);
    import gdl90_pkg::*;

    logic [15:0] crc_reg;
    logic [15:0] crc_next;
    logic        in_frame_reg;
    logic        in_frame_next;
    logic [15:0] crc_base;
    logic [15:0] crc_new;
    logic        accept;

    assign in_ch.ready = !q_full;
    assign accept      = in_ch.valid && in_ch.ready;

    assign crc_base = in_ch.first_byte ? CRC_SEED : crc_reg;
    assign crc_new  = crc_update(crc_base, in_ch.data_byte);

    // payload byte outside a frame is dropped
    assign q_push = accept && (in_ch.first_byte || in_frame_reg);

    assign q_cmd.first = in_ch.first_byte;
    assign q_cmd.last  = in_ch.last_byte;
    assign q_cmd.data  = in_ch.data_byte;
    assign q_cmd.crc   = crc_new;

    always_comb
    begin
        crc_next      = crc_reg;
        in_frame_next = in_frame_reg;
        if (q_push)
        begin
            if (in_ch.last_byte)
            begin
                crc_next      = CRC_SEED;
                in_frame_next = 1'b0;
            end
            else
            begin
                crc_next      = crc_new;
                in_frame_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg      <= CRC_SEED;
            in_frame_reg <= 1'b0;
        end
        else
        begin
            crc_reg      <= crc_next;
            in_frame_reg <= in_frame_next;
        end
    end

endmodule

>>> rtl/core/gdl90_cmd_fifo.sv
// ----------------------------------------------------------------------------
// gdl90_cmd_fifo
// Short command queue between front and back; head is shown directly.
// ----------------------------------------------------------------------------
module gdl90_cmd_fifo
#(
    parameter int DEPTH = 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  gdl90_pkg::cmd_t  push_cmd,
    output logic             full,
    input  logic             pop,
    output logic             empty,
    output gdl90_pkg::cmd_t  head_cmd
);
    import gdl90_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    cmd_t          mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg;
    logic [AW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          do_push;
    logic          do_pop;

    assign full     = (count_reg == FULL_CNT);
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_cmd = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> rtl/core/gdl90_back.sv
// ----------------------------------------------------------------------------
// gdl90_back
// Expands queued commands into framed, escaped bytes, one per unstalled cycle.
// ----------------------------------------------------------------------------
module gdl90_back
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_empty,
    input  gdl90_pkg::cmd_t  q_head,
    output logic             q_pop,
    gdl90_out_if.source      out_ch
);
    import gdl90_pkg::*;

    typedef enum logic [2:0] {
        S_START,
        S_DATA,
        S_DATA2,
        S_LO,
        S_LO2,
        S_HI,
        S_HI2,
        S_END
    } state_t;

    state_t     state_reg;
    state_t     state_next;
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       frame_end_reg;
    logic       run_last_reg;

    logic [7:0] emit_byte;
    logic       emit_end;
    logic       emit_done;
    logic       load;
    state_t     after_data;
    logic [7:0] crc_lo;
    logic [7:0] crc_hi;

    assign crc_lo     = q_head.crc[7:0];
    assign crc_hi     = q_head.crc[15:8];
    assign after_data = q_head.last ? S_LO : S_START;

    assign load  = !q_empty && (!out_valid_reg || out_ch.ready);
    assign q_pop = load && emit_done;

    always_comb
    begin
        emit_byte  = FLAG_BYTE;
        emit_end   = 1'b0;
        emit_done  = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            S_START, S_DATA:
            begin
                if (state_reg == S_START && q_head.first)
                begin
                    emit_byte  = FLAG_BYTE;
                    state_next = S_DATA;
                end
                else if (!q_head.first && needs_escape(q_head.data))
                begin
                    emit_byte  = ESC_BYTE;
                    state_next = S_DATA2;
                end
                else
                begin
                    // message id goes out unescaped
                    emit_byte  = q_head.data;
                    state_next = after_data;
                    emit_done  = !q_head.last;
                end
            end
            S_DATA2:
            begin
                emit_byte  = q_head.data ^ ESC_XOR;
                state_next = after_data;
                emit_done  = !q_head.last;
            end
            S_LO:
            begin
                if (needs_escape(crc_lo))
                begin
                    emit_byte  = ESC_BYTE;
                    state_next = S_LO2;
                end
                else
                begin
                    emit_byte  = crc_lo;
                    state_next = S_HI;
                end
            end
            S_LO2:
            begin
                emit_byte  = crc_lo ^ ESC_XOR;
                state_next = S_HI;
            end
            S_HI:
            begin
                if (needs_escape(crc_hi))
                begin
                    emit_byte  = ESC_BYTE;
                    state_next = S_HI2;
                end
                else
                begin
                    emit_byte  = crc_hi;
                    state_next = S_END;
                end
            end
            S_HI2:
            begin
                emit_byte  = crc_hi ^ ESC_XOR;
                state_next = S_END;
            end
            S_END:
            begin
                emit_byte  = FLAG_BYTE;
                emit_end   = 1'b1;
                emit_done  = 1'b1;
                state_next = S_START;
            end
            default:
            begin
                state_next = S_START;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_START;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg  <= emit_byte;
            frame_end_reg <= emit_end;
            run_last_reg  <= emit_done;
        end
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.out_byte  = out_byte_reg;
    assign out_ch.frame_end = frame_end_reg;
    assign out_ch.run_last  = run_last_reg;

endmodule

>>> dv/gdl90_frame_encoder_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gdl90_frame_encoder_tb
// Drives message bytes into the encoder and checks the framed byte stream
// against a local predictor of flags, byte stuffing and CRC-16. Directed
// frames cover id-only frames, restarts, orphan bytes and stuffed CRC bytes;
// random frames follow with random idles on both channels.
// ----------------------------------------------------------------------------
module gdl90_frame_encoder_tb;
    import gdl90_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       frame_end;
        logic       run_last;
    } framed_byte_t;

    logic clk;
    logic rst_n;

    gdl90_in_if  in_ch();
    gdl90_out_if out_ch();

    gdl90_frame_encoder uut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // predictor state
    logic [15:0]  crc_acc;
    logic         frame_open;
    framed_byte_t burst[$];
    framed_byte_t expected_stream[$];

    int  mismatch_count;
    bit  calm;          // no idles on either side while set

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        #12_000_000;
        $display("gdl90_frame_encoder_tb NOT OK");
        $finish;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic logic [15:0] crc_fold(input logic [7:0] hi);
        logic [15:0] r;
        r = {hi, 8'h00};
        repeat (8)
        begin
            if (r[15])
                r = {r[14:0], 1'b0} ^ CRC_POLY;
            else
                r = {r[14:0], 1'b0};
        end
        return r;
    endfunction

    function automatic logic [15:0] crc_next(input logic [15:0] crc, input logic [7:0] b);
        return crc_fold(crc[15:8]) ^ {crc[7:0], 8'h00} ^ {8'h00, b};
    endfunction

    function automatic void push_stuffed(input logic [7:0] b);
        if (b == ESC_BYTE || b == FLAG_BYTE)
        begin
            burst.push_back('{ESC_BYTE, 1'b0, 1'b0});
            burst.push_back('{b ^ ESC_XOR, 1'b0, 1'b0});
        end
        else
        begin
            burst.push_back('{b, 1'b0, 1'b0});
        end
    endfunction

    function automatic void encode_expected(input logic [7:0] d, input logic f, input logic l);
        framed_byte_t fb;
        if (f)
        begin
            // an id always restarts, dropping any open frame
            crc_acc    = crc_next(CRC_SEED, d);
            frame_open = 1'b1;
            burst.push_back('{FLAG_BYTE, 1'b0, 1'b0});
            burst.push_back('{d, 1'b0, 1'b0});
        end
        else
        begin
            if (!frame_open)
                return;
            crc_acc = crc_next(crc_acc, d);
            push_stuffed(d);
        end
        if (l)
        begin
            push_stuffed(crc_acc[7:0]);
            push_stuffed(crc_acc[15:8]);
            burst.push_back('{FLAG_BYTE, 1'b1, 1'b0});
            crc_acc    = CRC_SEED;
            frame_open = 1'b0;
        end
        while (burst.size() > 0)
        begin
            fb = burst.pop_front();
            fb.run_last = (burst.size() == 0);
            expected_stream.push_back(fb);
        end
    endfunction

    // ------------------------------------------------------------------
    // idles: mostly short, a few long
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    initial
    begin
        int run;
        int stall;
        out_ch.ready = 1'b1;
        @(negedge clk);
        forever
        begin
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 20);
            out_ch.ready <= 1'b1;
            repeat (run) @(negedge clk);
            stall = pick_gap();
            if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
        end
    end

    // ------------------------------------------------------------------
    // output checker
    // ------------------------------------------------------------------
    task automatic note_mismatch(input string what, input framed_byte_t want,
                                 input framed_byte_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: %s: expected byte %h end %b last %b, got byte %h end %b last %b",
                     $realtime, what, want.data, want.frame_end, want.run_last,
                     got.data, got.frame_end, got.run_last);
    endtask

    always @(posedge clk)
    begin
        framed_byte_t got;
        framed_byte_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got = '{out_ch.out_byte, out_ch.frame_end, out_ch.run_last};
            if (expected_stream.size() == 0)
            begin
                note_mismatch("unexpected transfer", '0, got);
            end
            else
            begin
                want = expected_stream.pop_front();
                if (got !== want)
                    note_mismatch("byte mismatch", want, got);
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers; each call starts and ends at a falling edge
    // ------------------------------------------------------------------
    task automatic send_msg_byte(input logic [7:0] d, input logic f, input logic l);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.data_byte  <= d;
        in_ch.first_byte <= f;
        in_ch.last_byte  <= l;
        do
            @(posedge clk);
        while (!in_ch.ready);
        encode_expected(d, f, l);
        @(negedge clk);
    endtask

    // sender idles until every expected byte has been seen
    task automatic wait_for_stream_drain();
        in_ch.valid <= 1'b0;
        while (expected_stream.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [7:0] pick_payload();
        if ($urandom_range(0, 99) < 15)
            return $urandom_range(0, 1) ? ESC_BYTE : FLAG_BYTE;
        return 8'($urandom_range(0, 255));
    endfunction

    // returns the number of bytes the block acts on
    task automatic send_frame(input int plen, input bit close, output int sent);
        if (plen == 0)
        begin
            send_msg_byte(8'($urandom_range(0, 255)), 1'b1, close);
        end
        else
        begin
            send_msg_byte(8'($urandom_range(0, 255)), 1'b1, 1'b0);
            for (int i = 0; i < plen; i++)
                send_msg_byte(pick_payload(), 1'b0, close && (i == plen - 1));
        end
        sent = plen + 1;
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_basic_frames();
        // payload extremes and both stuffed values
        send_msg_byte(8'h00, 1'b1, 1'b0);
        send_msg_byte(8'hFF, 1'b0, 1'b0);
        send_msg_byte(8'h7E, 1'b0, 1'b0);
        send_msg_byte(8'h7D, 1'b0, 1'b0);
        send_msg_byte(8'h00, 1'b0, 1'b0);
        send_msg_byte(8'h20, 1'b0, 1'b1);
        // id-only frames; the id goes out unstuffed
        send_msg_byte(FLAG_BYTE, 1'b1, 1'b1);
        send_msg_byte(8'hFF, 1'b1, 1'b1);
    endtask

    task automatic test_restart_and_orphans();
        send_msg_byte(8'h10, 1'b1, 1'b0);
        send_msg_byte(8'h01, 1'b0, 1'b0);
        // new id while open: old frame dropped with no trailer
        send_msg_byte(ESC_BYTE, 1'b1, 1'b0);
        send_msg_byte(8'h7E, 1'b0, 1'b1);
        // payload with no open frame is ignored, last_byte or not
        send_msg_byte(8'h55, 1'b0, 1'b0);
        send_msg_byte(8'h7E, 1'b0, 1'b1);
    endtask

    // pick the last two payload bytes so the CRC comes out as want_hi:want_lo
    task automatic test_stuffed_crc(input logic [7:0] id, input logic [7:0] want_lo,
                                    input logic [7:0] want_hi);
        logic [15:0] t0;
        logic [15:0] t1;
        logic [7:0]  mid_lo;
        send_msg_byte(id, 1'b1, 1'b0);
        t0 = crc_fold(crc_acc[15:8]);
        t1 = crc_fold(t0[15:8] ^ crc_acc[7:0]);
        mid_lo = want_hi ^ t1[15:8];
        send_msg_byte(t0[7:0] ^ mid_lo, 1'b0, 1'b0);
        t0 = crc_next(crc_acc, 8'h00);
        send_msg_byte(t0[7:0] ^ want_lo, 1'b0, 1'b1);
    endtask

    task automatic test_random_messages();
        int accepted;
        int frames;
        int r;
        int sent;
        accepted = 0;
        frames   = 0;
        while (accepted < 280)
        begin
            calm = (frames >= 20 && frames < 30);
            if (frames == 15)
                wait_for_stream_drain();
            r = $urandom_range(0, 99);
            if (r < 8)
            begin
                // noise: orphan byte, or stray payload into a truncated frame
                send_msg_byte(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
            end
            else if (r < 14)
            begin
                send_frame($urandom_range(0, 4), 1'b0, sent);
                accepted += sent;
            end
            else if (r < 17)
            begin
                send_frame($urandom_range(20, 40), 1'b1, sent);
                accepted += sent;
            end
            else
            begin
                send_frame($urandom_range(0, 8), 1'b1, sent);
                accepted += sent;
            end
            frames++;
        end
        calm = 1'b0;
    endtask

    initial
    begin
        rst_n            = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.data_byte  = 8'h00;
        in_ch.first_byte = 1'b0;
        in_ch.last_byte  = 1'b0;
        crc_acc          = CRC_SEED;
        frame_open       = 1'b0;
        mismatch_count   = 0;
        calm             = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_basic_frames();
        test_restart_and_orphans();
        test_stuffed_crc(8'h0A, FLAG_BYTE, ESC_BYTE);
        test_stuffed_crc(8'h14, ESC_BYTE, FLAG_BYTE);
        test_random_messages();

        wait_for_stream_drain();
        repeat (30) @(posedge clk);

        if (mismatch_count == 0 && expected_stream.size() == 0)
            $display("gdl90_frame_encoder_tb OK");
        else
            $display("gdl90_frame_encoder_tb NOT OK");
        $finish;
    end

endmodule
